FILE: hdl/fthd_pkg.sv
// Shared types and constants for the telemetry frame and hub decoder.
// No dependencies; the files that use it refer to this package by scoped names.
package fthd_pkg;

  // Link framing
  localparam logic [7:0] FLAG_BYTE     = 8'h7E;
  localparam logic [7:0] ESC_BYTE      = 8'h7D;
  localparam logic [7:0] ESC_XOR       = 8'h20;
  localparam logic [7:0] USER_FRAME_ID = 8'hFD;

  // Payload walk: length byte saturates, payload starts at byte 3
  localparam int unsigned PAYLOAD_START = 3;
  localparam logic [7:0]  MAX_PAYLOAD   = 8'd6;

  // Hub protocol
  localparam logic [7:0] HUB_START  = 8'h5E;
  localparam logic [7:0] HUB_ESC    = 8'h5D;
  localparam logic [7:0] HUB_XOR    = 8'h60;
  localparam logic [7:0] HUB_ID_MAX = 8'h3F;

  localparam logic [5:0] ID_ALTITUDE  = 6'h01;
  localparam logic [5:0] ID_LON_WHOLE = 6'h12;
  localparam logic [5:0] ID_LON_FRAC  = 6'h1A;
  localparam logic [5:0] ID_LAT_WHOLE = 6'h13;
  localparam logic [5:0] ID_LAT_FRAC  = 6'h1B;
  localparam logic [5:0] ID_EW_LETTER = 6'h22;
  localparam logic [5:0] ID_NS_LETTER = 6'h23;
  localparam logic [5:0] ID_TEMP2     = 6'h05;

  localparam logic [7:0] CHAR_N = 8'h4E;
  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] CHAR_W = 8'h57;

  // Queue between front and back (power of two)
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_START,
    FS_IN,
    FS_ESC,
    FS_READ,
    FS_PUSH,
    FS_CLOSE
  } front_state_t;

  typedef enum logic [1:0] {
    HB_IDLE,
    HB_ID,
    HB_LOW,
    HB_HIGH
  } hub_state_t;

  // One queue entry: either a payload byte for the hub parser or a snapshot request
  typedef struct packed {
    logic       is_snap;
    logic       closed;
    logic [7:0] data;
  } q_entry_t;

  typedef struct packed {
    logic [7:0] quot;
    logic [3:0] rem;
  } div10_t;

  // Divide a byte by ten: reciprocal multiply, exact for every 8-bit value
  function automatic div10_t div10(input logic [7:0] b);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  back;
    div10_t      res;
    prod     = {8'd0, b} * 16'd205;
    q        = prod[15:11];
    back     = {3'd0, q} * 8'd10;
    res.quot = {3'd0, q};
    res.rem  = 4'(b - back);
    return res;
  endfunction

endpackage

FILE: hdl/fthd_ifs.sv
// Channel interfaces of the telemetry frame and hub decoder: link bytes in,
// snapshots out, configuration writes. No dependencies.
interface fthd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  modport source (output valid, output raw_byte, input ready);
  modport sink   (input valid, input raw_byte, output ready);
endinterface

interface fthd_snap_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cur_altitude;
  logic [15:0]        cur_lat_whole;
  logic [15:0]        cur_lat_frac;
  logic [15:0]        cur_lon_whole;
  logic [15:0]        cur_lon_frac;
  logic [7:0]         cur_ns_letter;
  logic [7:0]         cur_ew_letter;
  logic [7:0]         cur_sats;
  logic [3:0]         cur_fix;
  logic               alt_valid;
  logic               fix_valid;
  logic               frame_closed;
  modport source (output valid, output cur_altitude, output cur_lat_whole,
                  output cur_lat_frac, output cur_lon_whole, output cur_lon_frac,
                  output cur_ns_letter, output cur_ew_letter, output cur_sats,
                  output cur_fix, output alt_valid, output fix_valid,
                  output frame_closed, input ready);
  modport sink   (input valid, input cur_altitude, input cur_lat_whole,
                  input cur_lat_frac, input cur_lon_whole, input cur_lon_frac,
                  input cur_ns_letter, input cur_ew_letter, input cur_sats,
                  input cur_fix, input alt_valid, input fix_valid,
                  input frame_closed, output ready);
endinterface

interface fthd_cfg_if;
  logic valid;
  logic ready;
  logic split_sat_byte;
  modport source (output valid, output split_sat_byte, input ready);
  modport sink   (input valid, input split_sat_byte, output ready);
endinterface

FILE: hdl/fthd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fthd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/fthd_queue.sv
// Short FIFO of q_entry_t between the frame front end and the hub back end.
// Depends on fthd_pkg.
module fthd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fthd_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output fthd_pkg::q_entry_t pop_data,
  output logic              empty
);

  localparam int unsigned PW = $clog2(fthd_pkg::QUEUE_DEPTH);

  fthd_pkg::q_entry_t slots [fthd_pkg::QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [PW:0]        fill;

  assign full     = (fill == (PW+1)'(fthd_pkg::QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");

endmodule

FILE: hdl/fthd_front.sv
// Frame front end: deframes and unstuffs link bytes into the frame store, queues a
// snapshot request per link byte and, on a user-data frame close, walks its payload
// into the queue. Depends on fthd_pkg, fthd_ifs and fthd_ram.
module fthd_front #(
  parameter int unsigned FRAME_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  fthd_byte_if.sink          link,
  output logic               q_push,
  output fthd_pkg::q_entry_t q_data,
  input  logic               q_full
);

  localparam int unsigned CW = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned IW = $clog2(FRAME_DEPTH);

  fthd_pkg::front_state_t state;
  fthd_pkg::front_state_t state_next;

  logic [CW-1:0] count;
  logic [7:0]    first_byte;
  logic [7:0]    len_byte;
  logic [IW-1:0] walk_idx;
  logic [CW-1:0] walk_end;

  logic          fire;
  logic          in_frame_phase;
  logic          is_flag;
  logic          is_esc;
  logic          store_en;
  logic [7:0]    store_val;
  logic          walk_need;
  logic [CW-1:0] end_calc;
  logic [7:0]    len_sat;
  logic          walk_last;
  logic [7:0]    rd_byte;

  assign in_frame_phase = (state == fthd_pkg::FS_IDLE) || (state == fthd_pkg::FS_START) ||
                          (state == fthd_pkg::FS_IN) || (state == fthd_pkg::FS_ESC);
  assign link.ready     = in_frame_phase && !q_full;
  assign fire           = link.valid && link.ready;
  assign is_flag        = (link.raw_byte == fthd_pkg::FLAG_BYTE);
  assign is_esc         = (link.raw_byte == fthd_pkg::ESC_BYTE);

  // Payload end: saturated length past the header, clipped to bytes held
  always_comb begin
    len_sat  = (len_byte > fthd_pkg::MAX_PAYLOAD) ? fthd_pkg::MAX_PAYLOAD : len_byte;
    end_calc = CW'(fthd_pkg::PAYLOAD_START) + CW'(len_sat);
    if (end_calc > count) begin
      end_calc = count;
    end
    walk_need = (count >= CW'(2)) && (first_byte == fthd_pkg::USER_FRAME_ID) &&
                (end_calc > CW'(fthd_pkg::PAYLOAD_START));
  end

  assign walk_last = ((CW'(walk_idx) + CW'(1)) == walk_end);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fthd_pkg::FS_IDLE: begin
        if (fire && is_flag) begin
          state_next = fthd_pkg::FS_START;
        end
      end
      fthd_pkg::FS_START, fthd_pkg::FS_IN: begin
        if (fire) begin
          if (is_flag) begin
            if (state == fthd_pkg::FS_IN) begin
              state_next = walk_need ? fthd_pkg::FS_READ : fthd_pkg::FS_IDLE;
            end
          end else if (is_esc) begin
            state_next = fthd_pkg::FS_ESC;
          end else begin
            state_next = fthd_pkg::FS_IN;
          end
        end
      end
      fthd_pkg::FS_ESC: begin
        if (fire) begin
          state_next = fthd_pkg::FS_IN;
        end
      end
      fthd_pkg::FS_READ: begin
        state_next = fthd_pkg::FS_PUSH;
      end
      fthd_pkg::FS_PUSH: begin
        if (!q_full) begin
          state_next = walk_last ? fthd_pkg::FS_CLOSE : fthd_pkg::FS_READ;
        end
      end
      fthd_pkg::FS_CLOSE: begin
        if (!q_full) begin
          state_next = fthd_pkg::FS_IDLE;
        end
      end
      default: state_next = fthd_pkg::FS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    q_push       = 1'b0;
    q_data       = '0;
    store_en     = 1'b0;
    store_val    = link.raw_byte;
    case (state)
      fthd_pkg::FS_IDLE: begin
        q_push         = fire;
        q_data.is_snap = 1'b1;
      end
      fthd_pkg::FS_START, fthd_pkg::FS_IN: begin
        q_data.is_snap = 1'b1;
        if (is_flag && state == fthd_pkg::FS_IN) begin
          // closing byte: its snapshot waits until the walk is done
          q_push        = fire && !walk_need;
          q_data.closed = 1'b1;
        end else begin
          q_push   = fire;
          store_en = fire && !is_flag && !is_esc;
        end
      end
      fthd_pkg::FS_ESC: begin
        q_push         = fire;
        q_data.is_snap = 1'b1;
        store_en       = fire;
        store_val      = link.raw_byte ^ fthd_pkg::ESC_XOR;
      end
      fthd_pkg::FS_PUSH: begin
        q_push      = !q_full;
        q_data.data = rd_byte;
      end
      fthd_pkg::FS_CLOSE: begin
        q_push         = !q_full;
        q_data.is_snap = 1'b1;
        q_data.closed  = 1'b1;
      end
      default: q_push = 1'b0;
    endcase
  end

  fthd_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_en && (count < CW'(FRAME_DEPTH))),
    .waddr (count[IW-1:0]),
    .wdata (store_val),
    .re    (state == fthd_pkg::FS_READ),
    .raddr (walk_idx),
    .rdata (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (store_en && count == CW'(0)) begin
      first_byte <= store_val;
    end
    if (store_en && count == CW'(1)) begin
      len_byte <= store_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fthd_pkg::FS_IDLE;
      count    <= '0;
      walk_idx <= '0;
      walk_end <= '0;
    end else begin
      state <= state_next;
      if (state == fthd_pkg::FS_IDLE && fire && is_flag) begin
        count <= '0;
      end else if (store_en && count < CW'(FRAME_DEPTH)) begin
        count <= count + 1'b1;
      end
      if (state_next == fthd_pkg::FS_READ && state == fthd_pkg::FS_IN) begin
        walk_idx <= IW'(fthd_pkg::PAYLOAD_START);
        walk_end <= end_calc;
      end else if (state == fthd_pkg::FS_PUSH && !q_full) begin
        walk_idx <= walk_idx + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue push while full");

  assert property (@(posedge clk) disable iff (rst)
                   state == fthd_pkg::FS_PUSH |-> CW'(walk_idx) < walk_end)
    else $error("payload walk ran past its end");

  assert property (@(posedge clk) disable iff (rst)
                   fire && state == fthd_pkg::FS_IN && is_flag
                   |=> state == fthd_pkg::FS_READ || state == fthd_pkg::FS_IDLE)
    else $error("frame close left the front end in a wrong state");

endmodule

FILE: hdl/fthd_back.sv
// Hub back end: drains the queue, runs payload bytes through the hub parser,
// keeps the decoded values and registers one snapshot per link byte.
// Depends on fthd_pkg and fthd_ifs.
module fthd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               split_sat_byte,
  input  fthd_pkg::q_entry_t q_data,
  input  logic               q_empty,
  output logic               q_pop,
  fthd_snap_if.source        snap
);

  fthd_pkg::hub_state_t hub_phase;
  fthd_pkg::hub_state_t hub_phase_next;

  logic        hub_escape;
  logic        hub_escape_next;
  logic [5:0]  hub_id;
  logic [5:0]  hub_id_next;
  logic [7:0]  hub_low;
  logic [7:0]  hub_low_next;
  logic        apply;

  logic [15:0] altitude;
  logic [15:0] lat_whole;
  logic [15:0] lat_frac;
  logic [15:0] lon_whole;
  logic [15:0] lon_frac;
  logic [7:0]  ns_letter;
  logic [7:0]  ew_letter;
  logic [7:0]  sat_count;
  logic [3:0]  fix_digit;
  logic        alt_seen;
  logic        fix_seen;
  logic [7:0]  ns_letter_next;
  logic [7:0]  ew_letter_next;

  logic        hub_en;
  logic        snap_take;
  logic        is_start;
  logic        hub_go;
  logic [7:0]  cval;
  logic [15:0] word;
  logic        letters_ok;
  fthd_pkg::div10_t sat_split;

  assign q_pop     = !q_empty && (!q_data.is_snap || !snap.valid || snap.ready);
  assign hub_en    = q_pop && !q_data.is_snap;
  assign snap_take = q_pop && q_data.is_snap;

  assign is_start = (q_data.data == fthd_pkg::HUB_START);
  assign cval     = hub_escape ? (q_data.data ^ fthd_pkg::HUB_XOR) : q_data.data;
  // an unescaped stuffing byte only arms the escape
  assign hub_go   = (hub_phase != fthd_pkg::HB_IDLE) && !is_start &&
                    (hub_escape || q_data.data != fthd_pkg::HUB_ESC);
  assign word     = {cval, hub_low};
  assign sat_split = fthd_pkg::div10(hub_low);

  // Next hub phase
  always_comb begin
    hub_phase_next = hub_phase;
    if (hub_en) begin
      if (is_start) begin
        hub_phase_next = fthd_pkg::HB_ID;
      end else if (hub_go) begin
        case (hub_phase)
          fthd_pkg::HB_ID: begin
            hub_phase_next = (cval > fthd_pkg::HUB_ID_MAX) ? fthd_pkg::HB_IDLE
                                                            : fthd_pkg::HB_LOW;
          end
          fthd_pkg::HB_LOW:  hub_phase_next = fthd_pkg::HB_HIGH;
          fthd_pkg::HB_HIGH: hub_phase_next = fthd_pkg::HB_IDLE;
          default:           hub_phase_next = fthd_pkg::HB_IDLE;
        endcase
      end
    end
  end

  // Parser outputs
  always_comb begin
    hub_escape_next = hub_escape;
    hub_id_next     = hub_id;
    hub_low_next    = hub_low;
    apply           = 1'b0;
    if (hub_en) begin
      if (is_start) begin
        hub_escape_next = 1'b0;
      end else if (hub_phase != fthd_pkg::HB_IDLE) begin
        hub_escape_next = !hub_escape && (q_data.data == fthd_pkg::HUB_ESC);
        if (hub_go) begin
          case (hub_phase)
            fthd_pkg::HB_ID: begin
              if (cval <= fthd_pkg::HUB_ID_MAX) begin
                hub_id_next = cval[5:0];
              end
            end
            fthd_pkg::HB_LOW:  hub_low_next = cval;
            fthd_pkg::HB_HIGH: apply = 1'b1;
            default:           apply = 1'b0;
          endcase
        end
      end
    end
  end

  always_comb begin
    ns_letter_next = ns_letter;
    ew_letter_next = ew_letter;
    if (apply && hub_id == fthd_pkg::ID_NS_LETTER) begin
      ns_letter_next = hub_low;
    end
    if (apply && hub_id == fthd_pkg::ID_EW_LETTER) begin
      ew_letter_next = hub_low;
    end
    letters_ok = (ns_letter_next == fthd_pkg::CHAR_N || ns_letter_next == fthd_pkg::CHAR_S) &&
                 (ew_letter_next == fthd_pkg::CHAR_E || ew_letter_next == fthd_pkg::CHAR_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hub_phase  <= fthd_pkg::HB_IDLE;
      hub_escape <= 1'b0;
      hub_id     <= '0;
      hub_low    <= '0;
      altitude   <= '0;
      lat_whole  <= '0;
      lat_frac   <= '0;
      lon_whole  <= '0;
      lon_frac   <= '0;
      ns_letter  <= '0;
      ew_letter  <= '0;
      sat_count  <= '0;
      fix_digit  <= '0;
      alt_seen   <= 1'b0;
      fix_seen   <= 1'b0;
    end else begin
      hub_phase  <= hub_phase_next;
      hub_escape <= hub_escape_next;
      hub_id     <= hub_id_next;
      hub_low    <= hub_low_next;
      ns_letter  <= ns_letter_next;
      ew_letter  <= ew_letter_next;
      if (apply) begin
        case (hub_id)
          fthd_pkg::ID_ALTITUDE: begin
            altitude <= word;
            alt_seen <= 1'b1;
          end
          fthd_pkg::ID_LON_WHOLE: lon_whole <= word;
          fthd_pkg::ID_LON_FRAC:  lon_frac  <= word;
          fthd_pkg::ID_LAT_WHOLE: lat_whole <= word;
          fthd_pkg::ID_LAT_FRAC:  lat_frac  <= word;
          fthd_pkg::ID_TEMP2: begin
            if (split_sat_byte) begin
              sat_count <= sat_split.quot;
              fix_digit <= sat_split.rem;
            end else begin
              sat_count <= hub_low;
              fix_digit <= '0;
            end
          end
          default: ;
        endcase
        if (letters_ok) begin
          fix_seen <= 1'b1;
        end
      end
    end
  end

  // Snapshot output register
  always_ff @(posedge clk) begin
    if (snap_take) begin
      snap.cur_altitude  <= altitude;
      snap.cur_lat_whole <= lat_whole;
      snap.cur_lat_frac  <= lat_frac;
      snap.cur_lon_whole <= lon_whole;
      snap.cur_lon_frac  <= lon_frac;
      snap.cur_ns_letter <= ns_letter;
      snap.cur_ew_letter <= ew_letter;
      snap.cur_sats      <= sat_count;
      snap.cur_fix       <= split_sat_byte ? fix_digit : 4'd0;
      snap.alt_valid     <= alt_seen;
      snap.fix_valid     <= fix_seen;
      snap.frame_closed  <= q_data.closed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap.valid <= 1'b0;
    end else if (snap_take) begin
      snap.valid <= 1'b1;
    end else if (snap.ready) begin
      snap.valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(hub_en && snap_take))
    else $error("one queue entry treated as both hub byte and snapshot");

  assert property (@(posedge clk) disable iff (rst)
                   hub_en && is_start |=> hub_phase == fthd_pkg::HB_ID && !hub_escape)
    else $error("hub start byte did not restart the parser");

endmodule

FILE: hdl/telemetry_frame_and_hub_decoder.sv
// Top level of the telemetry frame and hub decoder.
// Depends on fthd_pkg, fthd_ifs, fthd_ram, fthd_queue, fthd_front and fthd_back.
//
// Usage:
//   link  - one serial link byte per item (raw_byte).
//   snap  - one snapshot item per link byte, in order: decoded altitude,
//           position words, hemisphere letters, satellites/fix, sticky flags
//           and frame_closed for the byte that ended a frame.
//   cfg   - single-register write port (split_sat_byte); always ready, write
//           only while the block is idle.
// Flow: an ordinary byte is written into the queue, then taken into the snapshot
// output register. A byte that closes a user-data frame holds link while each
// payload byte (up to six) is read from the frame store, then queued; its own
// snapshot request is queued after the last one.
// A four-entry queue parts the frame front end from the hub back end; when
// snap stalls, the queue fills and link ready drops, with nothing lost.
// Reset (rst, synchronous) clears all decoded values, flags and the
// register; the frame store needs no clearing.
module telemetry_frame_and_hub_decoder #(
  parameter int unsigned FRAME_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  fthd_byte_if.sink   link,
  fthd_snap_if.source snap,
  fthd_cfg_if.sink    cfg
);

  logic               split_sat_byte;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  fthd_pkg::q_entry_t q_in;
  fthd_pkg::q_entry_t q_out;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_sat_byte <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      split_sat_byte <= cfg.split_sat_byte;
    end
  end

  fthd_front #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .link   (link),
    .q_push (q_push),
    .q_data (q_in),
    .q_full (q_full)
  );

  fthd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  fthd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .split_sat_byte (split_sat_byte),
    .q_data         (q_out),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .snap           (snap)
  );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for telemetry_frame_and_hub_decoder: link bytes in, one snapshot out per
// byte, checked against an in-bench mirror of the framing and hub decoding.
// Depends on fthd_pkg, the channel interfaces in fthd_ifs and the decoder RTL.
module tb;

  localparam int unsigned FRAME_DEPTH   = 16;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 30;

  typedef struct {
    logic [15:0] altitude;
    logic [15:0] lat_whole;
    logic [15:0] lat_frac;
    logic [15:0] lon_whole;
    logic [15:0] lon_frac;
    logic [7:0]  ns_letter;
    logic [7:0]  ew_letter;
    logic [7:0]  sats;
    logic [3:0]  fix;
    logic        alt_ok;
    logic        fix_ok;
    logic        closed;
  } snapshot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fthd_byte_if link ();
  fthd_snap_if snap ();
  fthd_cfg_if  cfg ();

  telemetry_frame_and_hub_decoder #(.FRAME_DEPTH(FRAME_DEPTH)) dut (
    .clk  (clk),
    .rst  (rst),
    .link (link),
    .snap (snap),
    .cfg  (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the decoder state
  logic                   split_mode = 1'b0;
  fthd_pkg::front_state_t fr_state   = fthd_pkg::FS_IDLE;
  int unsigned            fr_count   = 0;
  logic [7:0]             fr_store [FRAME_DEPTH];
  fthd_pkg::hub_state_t   hb_state   = fthd_pkg::HB_IDLE;
  logic                   hb_esc     = 1'b0;
  logic [5:0]             hb_id      = '0;
  logic [7:0]             hb_low     = '0;
  logic [15:0]            altitude   = '0;
  logic [15:0]            lat_whole  = '0;
  logic [15:0]            lat_frac   = '0;
  logic [15:0]            lon_whole  = '0;
  logic [15:0]            lon_frac   = '0;
  logic [7:0]             ns_letter  = '0;
  logic [7:0]             ew_letter  = '0;
  logic [7:0]             sat_count  = '0;
  logic [3:0]             fix_digit  = '0;
  logic                   alt_seen   = 1'b0;
  logic                   fix_seen   = 1'b0;

  snapshot_t    snap_expect [$];
  logic [7:0]   hub_stream [$];
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct     = 0;
  int unsigned  live_items    = 0;
  int unsigned  mismatches    = 0;
  int unsigned  cycle_count   = 0;

  function automatic void apply_hub_word(input logic [7:0] hi);
    logic [15:0] word;
    word = {hi, hb_low};
    case (hb_id)
      fthd_pkg::ID_ALTITUDE: begin
        altitude = word;
        alt_seen = 1'b1;
      end
      fthd_pkg::ID_LON_WHOLE: lon_whole = word;
      fthd_pkg::ID_LON_FRAC:  lon_frac  = word;
      fthd_pkg::ID_LAT_WHOLE: lat_whole = word;
      fthd_pkg::ID_LAT_FRAC:  lat_frac  = word;
      fthd_pkg::ID_EW_LETTER: ew_letter = hb_low;
      fthd_pkg::ID_NS_LETTER: ns_letter = hb_low;
      fthd_pkg::ID_TEMP2: begin
        if (split_mode) begin
          sat_count = hb_low / 8'd10;
          fix_digit = 4'(hb_low % 8'd10);
        end else begin
          sat_count = hb_low;
          fix_digit = '0;
        end
      end
      default: ;
    endcase
    if ((ns_letter == fthd_pkg::CHAR_N || ns_letter == fthd_pkg::CHAR_S) &&
        (ew_letter == fthd_pkg::CHAR_E || ew_letter == fthd_pkg::CHAR_W))
      fix_seen = 1'b1;
  endfunction

  function automatic void feed_hub(input logic [7:0] c);
    logic [7:0] d;
    d = c;
    if (d == fthd_pkg::HUB_START) begin
      hb_state = fthd_pkg::HB_ID;
      hb_esc   = 1'b0;
      return;
    end
    if (hb_state == fthd_pkg::HB_IDLE) return;
    if (hb_esc) begin
      d      = d ^ fthd_pkg::HUB_XOR;
      hb_esc = 1'b0;
    end else if (d == fthd_pkg::HUB_ESC) begin
      hb_esc = 1'b1;
      return;
    end
    case (hb_state)
      fthd_pkg::HB_ID: begin
        if (d > fthd_pkg::HUB_ID_MAX) begin
          hb_state = fthd_pkg::HB_IDLE;
        end else begin
          hb_id    = d[5:0];
          hb_state = fthd_pkg::HB_LOW;
        end
      end
      fthd_pkg::HB_LOW: begin
        hb_low   = d;
        hb_state = fthd_pkg::HB_HIGH;
      end
      default: begin
        hb_state = fthd_pkg::HB_IDLE;
        apply_hub_word(d);
      end
    endcase
  endfunction

  function automatic void walk_payload();
    int unsigned len;
    int unsigned stop;
    if (fr_count < 2 || fr_store[0] != fthd_pkg::USER_FRAME_ID) return;
    len  = (fr_store[1] > fthd_pkg::MAX_PAYLOAD) ? fthd_pkg::MAX_PAYLOAD : fr_store[1];
    stop = fthd_pkg::PAYLOAD_START + len;
    if (stop > fr_count) stop = fr_count;
    for (int unsigned i = fthd_pkg::PAYLOAD_START; i < stop && i < FRAME_DEPTH; i++)
      feed_hub(fr_store[i]);
  endfunction

  function automatic void store_frame_byte(input logic [7:0] b);
    if (fr_count < FRAME_DEPTH) begin
      fr_store[fr_count] = b;
      fr_count++;
    end
  endfunction

  function automatic snapshot_t decode_link_byte(input logic [7:0] b);
    snapshot_t s;
    logic      closed;
    closed = 1'b0;
    case (fr_state)
      fthd_pkg::FS_IDLE: begin
        if (b == fthd_pkg::FLAG_BYTE) begin
          fr_count = 0;
          fr_state = fthd_pkg::FS_START;
        end
      end
      fthd_pkg::FS_START, fthd_pkg::FS_IN: begin
        if (b == fthd_pkg::FLAG_BYTE) begin
          // a second flag straight after the opening one keeps the start phase
          if (fr_state == fthd_pkg::FS_IN) begin
            walk_payload();
            closed   = 1'b1;
            fr_state = fthd_pkg::FS_IDLE;
          end
        end else if (b == fthd_pkg::ESC_BYTE) begin
          fr_state = fthd_pkg::FS_ESC;
        end else begin
          store_frame_byte(b);
          fr_state = fthd_pkg::FS_IN;
        end
      end
      default: begin
        store_frame_byte(b ^ fthd_pkg::ESC_XOR);
        fr_state = fthd_pkg::FS_IN;
      end
    endcase
    s.altitude  = altitude;
    s.lat_whole = lat_whole;
    s.lat_frac  = lat_frac;
    s.lon_whole = lon_whole;
    s.lon_frac  = lon_frac;
    s.ns_letter = ns_letter;
    s.ew_letter = ew_letter;
    s.sats      = sat_count;
    s.fix       = split_mode ? fix_digit : 4'd0;
    s.alt_ok    = alt_seen;
    s.fix_ok    = fix_seen;
    s.closed    = closed;
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // Snapshot checker
  always @(posedge clk) begin
    snapshot_t want;
    if (!rst && snap.valid && snap.ready) begin
      if (snap_expect.size() == 0) begin
        mismatches++;
        $display("%0t mismatch snapshot: expected none actual alt %h closed %b",
                 $time, snap.cur_altitude, snap.frame_closed);
      end else begin
        want = snap_expect.pop_front();
        check_field("cur_altitude", want.altitude, snap.cur_altitude);
        check_field("cur_lat_whole", want.lat_whole, snap.cur_lat_whole);
        check_field("cur_lat_frac", want.lat_frac, snap.cur_lat_frac);
        check_field("cur_lon_whole", want.lon_whole, snap.cur_lon_whole);
        check_field("cur_lon_frac", want.lon_frac, snap.cur_lon_frac);
        check_field("cur_ns_letter", want.ns_letter, snap.cur_ns_letter);
        check_field("cur_ew_letter", want.ew_letter, snap.cur_ew_letter);
        check_field("cur_sats", want.sats, snap.cur_sats);
        check_field("cur_fix", want.fix, snap.cur_fix);
        check_field("alt_valid", want.alt_ok, snap.alt_valid);
        check_field("fix_valid", want.fix_ok, snap.fix_valid);
        check_field("frame_closed", want.closed, snap.frame_closed);
      end
    end
  end

  always @(posedge clk) snap.ready <= !rst && ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      link.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    link.valid    <= 1'b1;
    link.raw_byte <= b;
    @(posedge clk);
    while (!link.ready) @(posedge clk);
    // bytes dropped outside a frame do not count as traffic
    if (fr_state != fthd_pkg::FS_IDLE || b == fthd_pkg::FLAG_BYTE) live_items++;
    snap_expect.push_back(decode_link_byte(b));
  endtask

  task automatic send_stuffed(input logic [7:0] b);
    if (b == fthd_pkg::FLAG_BYTE || b == fthd_pkg::ESC_BYTE) begin
      send_byte(fthd_pkg::ESC_BYTE);
      send_byte(b ^ fthd_pkg::ESC_XOR);
    end else begin
      send_byte(b);
    end
  endtask

  task automatic wait_for_snapshots();
    link.valid <= 1'b0;
    while (snap_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_split(input logic v);
    cfg.valid          <= 1'b1;
    cfg.split_sat_byte <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid  <= 1'b0;
    split_mode = v;
  endtask

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return fthd_pkg::HUB_ESC;
      3: return fthd_pkg::HUB_START;
      4: return fthd_pkg::FLAG_BYTE;
      5: return fthd_pkg::ESC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_hub_data(input logic [7:0] b);
    if (b == fthd_pkg::HUB_START || b == fthd_pkg::HUB_ESC || $urandom_range(0, 19) == 0) begin
      hub_stream.push_back(fthd_pkg::HUB_ESC);
      hub_stream.push_back(b ^ fthd_pkg::HUB_XOR);
    end else begin
      hub_stream.push_back(b);
    end
  endfunction

  function automatic void add_hub_word();
    logic [5:0] id;
    logic [7:0] lo;
    hub_stream.push_back(fthd_pkg::HUB_START);
    case ($urandom_range(0, 11))
      0:       id = fthd_pkg::ID_ALTITUDE;
      1:       id = fthd_pkg::ID_LON_WHOLE;
      2:       id = fthd_pkg::ID_LON_FRAC;
      3:       id = fthd_pkg::ID_LAT_WHOLE;
      4:       id = fthd_pkg::ID_LAT_FRAC;
      5, 6:    id = fthd_pkg::ID_EW_LETTER;
      7, 8:    id = fthd_pkg::ID_NS_LETTER;
      9:       id = fthd_pkg::ID_TEMP2;
      10:      id = 6'($urandom_range(0, 63));
      default: begin
        // out-of-range id sends the parser back to idle
        hub_stream.push_back(8'($urandom_range(fthd_pkg::HUB_ID_MAX + 1,
                                               fthd_pkg::HUB_ESC - 1)));
        return;
      end
    endcase
    lo = pick_data();
    if (id == fthd_pkg::ID_EW_LETTER && $urandom_range(0, 3) != 0)
      lo = $urandom_range(0, 1) ? fthd_pkg::CHAR_E : fthd_pkg::CHAR_W;
    if (id == fthd_pkg::ID_NS_LETTER && $urandom_range(0, 3) != 0)
      lo = $urandom_range(0, 1) ? fthd_pkg::CHAR_N : fthd_pkg::CHAR_S;
    push_hub_data(8'(id));
    push_hub_data(lo);
    // now and then cut the word short so the next start restarts it
    if ($urandom_range(0, 15) != 0) push_hub_data(pick_data());
  endfunction

  task automatic send_user_frame();
    logic [7:0]  chunk [$];
    int unsigned k;
    int unsigned len_field;
    int unsigned extra;
    while (hub_stream.size() < 8) add_hub_word();
    k = $urandom_range(0, 6);
    repeat (k) chunk.push_back(hub_stream.pop_front());
    case ($urandom_range(0, 9))
      0:       len_field = $urandom_range(fthd_pkg::MAX_PAYLOAD + 1, 255);
      1:       len_field = $urandom_range(0, k);
      default: len_field = k;
    endcase
    extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    send_byte(fthd_pkg::FLAG_BYTE);
    if ($urandom_range(0, 7) == 0) send_byte(fthd_pkg::FLAG_BYTE);
    if ($urandom_range(0, 5) == 0) begin
      send_byte(fthd_pkg::ESC_BYTE);
      send_byte(fthd_pkg::USER_FRAME_ID ^ fthd_pkg::ESC_XOR);
    end else begin
      send_stuffed(fthd_pkg::USER_FRAME_ID);
    end
    send_stuffed(8'(len_field));
    send_stuffed(8'($urandom_range(0, 255)));
    foreach (chunk[i]) send_stuffed(chunk[i]);
    repeat (extra) send_stuffed(8'($urandom_range(0, 255)));
    send_byte(fthd_pkg::FLAG_BYTE);
  endtask

  // Random-content frame, long enough at times to overrun the frame store
  task automatic send_plain_frame(input logic user);
    int unsigned n;
    n = $urandom_range(0, 22);
    send_byte(fthd_pkg::FLAG_BYTE);
    if (user) send_stuffed(fthd_pkg::USER_FRAME_ID);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        // escaped flag is stored as data and does not close
        send_byte(fthd_pkg::ESC_BYTE);
        send_byte(fthd_pkg::FLAG_BYTE);
      end else begin
        send_stuffed(8'($urandom_range(0, 255)));
      end
    end
    send_byte(fthd_pkg::FLAG_BYTE);
  endtask

  task automatic test_directed_frames();
    logic [7:0] seq [$];
    seq = '{fthd_pkg::FLAG_BYTE, fthd_pkg::FLAG_BYTE, fthd_pkg::ESC_BYTE,
            fthd_pkg::USER_FRAME_ID ^ fthd_pkg::ESC_XOR, 8'd6, 8'h00,
            fthd_pkg::HUB_START, 8'(fthd_pkg::ID_ALTITUDE), 8'h00, 8'h80,
            fthd_pkg::FLAG_BYTE,
            fthd_pkg::FLAG_BYTE, fthd_pkg::USER_FRAME_ID, 8'd4, 8'hFF,
            fthd_pkg::HUB_START, 8'(fthd_pkg::ID_TEMP2), 8'hFF, 8'hFF,
            fthd_pkg::FLAG_BYTE,
            fthd_pkg::FLAG_BYTE, fthd_pkg::USER_FRAME_ID, 8'd6, 8'h00,
            fthd_pkg::ESC_BYTE, fthd_pkg::FLAG_BYTE, fthd_pkg::HUB_ID_MAX + 8'd1,
            fthd_pkg::FLAG_BYTE};
    send_idle_pct = 0;
    stall_pct     = 0;
    foreach (seq[i]) send_byte(seq[i]);
    wait_for_snapshots();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned hold_pct,
                                     input int unsigned count);
    int unsigned first;
    int unsigned pick;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    first         = live_items;
    while (live_items - first < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)
        send_user_frame();
      else if (pick < 75)
        send_plain_frame(1'b1);
      else if (pick < 85)
        send_plain_frame(1'b0);
      else
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
    wait_for_snapshots();
  endtask

  initial begin
    link.valid         = 1'b0;
    link.raw_byte      = '0;
    cfg.valid          = 1'b0;
    cfg.split_sat_byte = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_split(1'b1);
    test_directed_frames();
    set_split(1'b0);
    test_random_traffic(0, 0, 240);
    set_split(1'b1);
    test_random_traffic(71, 0, 240);
    set_split(1'b0);
    test_random_traffic(0, 71, 240);
    set_split(1'($urandom_range(0, 1)));
    test_random_traffic(33, 33, 230);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/fthd_pkg.sv
hdl/fthd_ifs.sv
hdl/fthd_ram.sv
hdl/fthd_queue.sv
hdl/fthd_front.sv
hdl/fthd_back.sv
hdl/telemetry_frame_and_hub_decoder.sv
dv/tb.sv
